// File: rtl/core/lpsm_pkg.sv
`timescale 1ns / 1ps

package lpsm_pkg;

   // Bytes per point record in a high-resolution packet
   localparam int unsigned POINT_BYTES  = 14;
   localparam int unsigned HEADER_BYTES = 36;

   localparam logic [15:0] EXPECTED_POINTS_RESET = 16'd96;
   localparam logic [7:0]  HIGH_TYPE_CODE_RESET  = 8'd1;
   localparam logic [15:0] LOSS_WINDOW_RESET     = 16'd1024;

   localparam int unsigned REQ_DATA_WIDTH = 224;
   localparam int unsigned RSP_DATA_WIDTH = 448;
   localparam int unsigned CSR_DATA_WIDTH = 16;

   typedef enum logic [1:0] {
      CSR_EXPECTED_POINTS = 2'd0,
      CSR_HIGH_TYPE_CODE  = 2'd1,
      CSR_LOSS_WINDOW     = 2'd2
   } csr_index_type;

   typedef enum logic {
      ACTION_HEADER = 1'b0,
      ACTION_POINT  = 1'b1
   } action_type;

   typedef struct packed {
      logic [15:0] expected_points;
      logic [7:0]  high_type_code;
      logic [15:0] loss_window;
   } cfg_type;

   // Declared high member first: seq_count lands in the lowest bits
   typedef struct packed {
      action_type         action;
      logic signed [31:0] coord_z;
      logic signed [31:0] coord_y;
      logic signed [31:0] coord_x;
      logic [7:0]         data_kind;
      logic [15:0]        packet_length;
      logic [15:0]        point_count;
      logic [63:0]        stamp_ns;
      logic [7:0]         frame_count;
      logic [15:0]        seq_count;
   } item_type;

   typedef struct packed {
      logic [63:0] last_stamp;
      logic [63:0] first_stamp;
      logic [31:0] bad_length_total;
      logic [31:0] bad_count_total;
      logic [31:0] regress_total;
      logic [31:0] frame_total;
      logic [31:0] duplicate_total;
      logic [31:0] missed_total;
      logic [47:0] zero_point_total;
      logic [47:0] point_total;
      logic [31:0] packet_total;
   } snap_type;

   function automatic logic [31:0] sat_add32(input logic [31:0] acc, input logic [31:0] inc);
      logic [32:0] sum;
      sum = {1'b0, acc} + {1'b0, inc};
      return sum[32] ? {32{1'b1}} : sum[31:0];
   endfunction

   function automatic logic [47:0] sat_add48(input logic [47:0] acc, input logic [47:0] inc);
      logic [48:0] sum;
      sum = {1'b0, acc} + {1'b0, inc};
      return sum[48] ? {48{1'b1}} : sum[47:0];
   endfunction

endpackage

// File: rtl/core/lidar_packet_stream_monitor_unit.sv
`timescale 1ns / 1ps

// Lidar packet stream monitor.
// req_* carries one request per beat: tuser says header (0) or point (1),
// tdata carries the header fields and the point coordinates.
// rsp_* returns one snapshot of all statistics counters for every request,
// in request order.
// csr_* writes the expected point count, the high-resolution type code and
// the loss window; write only while no request is in flight.
// A request accepted on req_* passes through the input register, then the
// result register, before its result shows on rsp_*.
// Throughput: one request per cycle while rsp_tready is high; the
// counter update is a single pass between the input and result registers.
// A stalled rsp_tready holds the result; one more request parks in the
// input register, then req_tready drops until the result is taken.
// Reset clears all counters, stamps and sequence history, loads the
// register defaults (96 points, type code 1, window 1024) and empties
// both stages.
module lidar_packet_stream_monitor_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // seq_count, frame_count, stamp_ns, point_count, packet_length,
   // data_kind, coord_x, coord_y, coord_z
   input  logic [lpsm_pkg::REQ_DATA_WIDTH-1:0]   req_tdata,
   // action
   input  logic                                  req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // packet_total, point_total, zero_point_total, missed_total,
   // duplicate_total, frame_total, regress_total, bad_count_total,
   // bad_length_total, first_stamp, last_stamp
   output logic [lpsm_pkg::RSP_DATA_WIDTH-1:0]   rsp_tdata,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [1:0]                            csr_index,
   input  logic [lpsm_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);

   lpsm_pkg::cfg_type  cfg_ff, cfg_in;
   lpsm_pkg::item_type in_item_ff, in_item_in;
   logic               in_valid_ff, in_valid_in;
   lpsm_pkg::snap_type rsp_snap_ff, rsp_snap_in;
   logic               rsp_valid_ff, rsp_valid_in;
   lpsm_pkg::snap_type snap;
   logic               advance;
   logic               req_accept;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (lpsm_pkg::csr_index_type'(csr_index))
            lpsm_pkg::CSR_EXPECTED_POINTS: cfg_in.expected_points = csr_wdata;
            lpsm_pkg::CSR_HIGH_TYPE_CODE:  cfg_in.high_type_code  = csr_wdata[7:0];
            lpsm_pkg::CSR_LOSS_WINDOW:     cfg_in.loss_window     = csr_wdata;
            default:                       cfg_in = cfg_ff;
         endcase
      end
   end

   // Move the held request into the result register when it is free
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      in_item_in  = in_item_ff;
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_item_in  = lpsm_pkg::item_type'({req_tuser, req_tdata});
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_snap_in  = rsp_snap_ff;
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_snap_in  = snap;
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   lpsm_stats u_stats (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .cfg     (cfg_ff),
      .item    (in_item_ff),
      .snap    (snap)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.expected_points <= lpsm_pkg::EXPECTED_POINTS_RESET;
         cfg_ff.high_type_code  <= lpsm_pkg::HIGH_TYPE_CODE_RESET;
         cfg_ff.loss_window     <= lpsm_pkg::LOSS_WINDOW_RESET;
         in_valid_ff            <= 1'b0;
         rsp_valid_ff           <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      rsp_snap_ff <= rsp_snap_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_snap_ff;

`ifndef NO_ASSERTIONS
   a_advance_gives_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("advanced request produced no result");

   a_header_updates_stamp: assert property (@(posedge clock) disable iff (reset)
      (advance && in_item_ff.action == lpsm_pkg::ACTION_HEADER) |=>
      (rsp_snap_ff.last_stamp == $past(in_item_ff.stamp_ns)
       && rsp_snap_ff.packet_total != 32'd0))
      else $error("header result lacks its stamp or packet count");

   a_held_request_kept: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_item_ff)))
      else $error("held request lost while result stage is busy");
`endif

endmodule

// File: rtl/core/lpsm_stats.sv
`timescale 1ns / 1ps

module lpsm_stats (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  lpsm_pkg::cfg_type  cfg,
   input  lpsm_pkg::item_type item,
   output lpsm_pkg::snap_type snap
);

   logic        seen_before_ff, seen_before_in;
   logic [15:0] prev_seq_ff, prev_seq_in;
   logic [7:0]  prev_frame_ff, prev_frame_in;
   logic [63:0] prev_stamp_ff, prev_stamp_in;
   logic [63:0] start_stamp_ff, start_stamp_in;
   logic        in_high_ff, in_high_in;
   logic [31:0] packets_ff, packets_in;
   logic [47:0] points_ff, points_in;
   logic [47:0] zero_points_ff, zero_points_in;
   logic [31:0] lost_ff, lost_in;
   logic [31:0] dups_ff, dups_in;
   logic [31:0] frames_ff, frames_in;
   logic [31:0] regress_ff, regress_in;
   logic [31:0] bad_counts_ff, bad_counts_in;
   logic [31:0] bad_lengths_ff, bad_lengths_in;

   logic        high;
   logic [15:0] gap;
   logic [15:0] want_length;
   logic        zero_point;

   assign high        = (item.data_kind == cfg.high_type_code);
   assign gap         = item.seq_count - prev_seq_ff;
   assign want_length = 16'(lpsm_pkg::HEADER_BYTES)
                        + 16'(item.point_count * 16'(lpsm_pkg::POINT_BYTES));
   assign zero_point  = (item.coord_x == 32'sd0) && (item.coord_y == 32'sd0)
                        && (item.coord_z == 32'sd0);

   always_comb begin
      seen_before_in = seen_before_ff;
      prev_seq_in    = prev_seq_ff;
      prev_frame_in  = prev_frame_ff;
      prev_stamp_in  = prev_stamp_ff;
      start_stamp_in = start_stamp_ff;
      in_high_in     = in_high_ff;
      packets_in     = packets_ff;
      points_in      = points_ff;
      zero_points_in = zero_points_ff;
      lost_in        = lost_ff;
      dups_in        = dups_ff;
      frames_in      = frames_ff;
      regress_in     = regress_ff;
      bad_counts_in  = bad_counts_ff;
      bad_lengths_in = bad_lengths_ff;
      if (advance) begin
         if (item.action == lpsm_pkg::ACTION_HEADER) begin
            packets_in = lpsm_pkg::sat_add32(packets_ff, 32'd1);
            if (item.point_count != cfg.expected_points) begin
               bad_counts_in = lpsm_pkg::sat_add32(bad_counts_ff, 32'd1);
            end
            if (high) begin
               if (item.packet_length != want_length) begin
                  bad_lengths_in = lpsm_pkg::sat_add32(bad_lengths_ff, 32'd1);
               end
               points_in = lpsm_pkg::sat_add48(points_ff, {32'd0, item.point_count});
            end
            in_high_in = high;
            if (!seen_before_ff) begin
               seen_before_in = 1'b1;
               start_stamp_in = item.stamp_ns;
            end else begin
               if (gap == 16'd0) begin
                  dups_in = lpsm_pkg::sat_add32(dups_ff, 32'd1);
               end else if (gap > 16'd1 && gap < cfg.loss_window) begin
                  // gap minus one packets went missing
                  lost_in = lpsm_pkg::sat_add32(lost_ff, {16'd0, gap - 16'd1});
               end
               if (item.frame_count != prev_frame_ff) begin
                  frames_in = lpsm_pkg::sat_add32(frames_ff, 32'd1);
               end
               if (item.stamp_ns < prev_stamp_ff) begin
                  regress_in = lpsm_pkg::sat_add32(regress_ff, 32'd1);
               end
            end
            prev_seq_in   = item.seq_count;
            prev_frame_in = item.frame_count;
            prev_stamp_in = item.stamp_ns;
         end else if (in_high_ff && zero_point) begin
            zero_points_in = lpsm_pkg::sat_add48(zero_points_ff, 48'd1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_before_ff <= 1'b0;
         prev_seq_ff    <= '0;
         prev_frame_ff  <= '0;
         prev_stamp_ff  <= '0;
         start_stamp_ff <= '0;
         in_high_ff     <= 1'b0;
         packets_ff     <= '0;
         points_ff      <= '0;
         zero_points_ff <= '0;
         lost_ff        <= '0;
         dups_ff        <= '0;
         frames_ff      <= '0;
         regress_ff     <= '0;
         bad_counts_ff  <= '0;
         bad_lengths_ff <= '0;
      end else begin
         seen_before_ff <= seen_before_in;
         prev_seq_ff    <= prev_seq_in;
         prev_frame_ff  <= prev_frame_in;
         prev_stamp_ff  <= prev_stamp_in;
         start_stamp_ff <= start_stamp_in;
         in_high_ff     <= in_high_in;
         packets_ff     <= packets_in;
         points_ff      <= points_in;
         zero_points_ff <= zero_points_in;
         lost_ff        <= lost_in;
         dups_ff        <= dups_in;
         frames_ff      <= frames_in;
         regress_ff     <= regress_in;
         bad_counts_ff  <= bad_counts_in;
         bad_lengths_ff <= bad_lengths_in;
      end
   end

   // Snapshot reflects the state after this request
   always_comb begin
      snap.packet_total     = packets_in;
      snap.point_total      = points_in;
      snap.zero_point_total = zero_points_in;
      snap.missed_total     = lost_in;
      snap.duplicate_total  = dups_in;
      snap.frame_total      = frames_in;
      snap.regress_total    = regress_in;
      snap.bad_count_total  = bad_counts_in;
      snap.bad_length_total = bad_lengths_in;
      snap.first_stamp      = start_stamp_in;
      snap.last_stamp       = prev_stamp_in;
   end

endmodule
